// ===== hw/rtl/vertex_normal_tangent_accumulate_macros.svh =====
// Assertion macros for the vertex normal and tangent block.
`ifndef VERTEX_NORMAL_TANGENT_ACCUMULATE_MACROS_SVH
`define VERTEX_NORMAL_TANGENT_ACCUMULATE_MACROS_SVH
`ifndef SYNTHESIS
`define VNT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define VNT_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define VNT_ASSERT(label, clk, rst_n, prop)
`define VNT_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== hw/rtl/vnt_pkg.sv =====
// ---------------------------------------------------------------------------
// vnt_pkg
// Shared types and constants of the vertex normal and tangent block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package vnt_pkg;
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_TRI  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // number of vertex entries, a power of two
    localparam int VERTEX_COUNT = 1024;

    // request to the divide / root unit
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [63:0] den;
    } vnt_div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } vnt_div_rsp_t;
endpackage

// ===== hw/rtl/vertex_normal_tangent_accumulate.sv =====
// ---------------------------------------------------------------------------
// vertex_normal_tangent_accumulate
// Per-vertex normal sums and texture-space tangents of an indexed mesh.
// ---------------------------------------------------------------------------
// channel  dir  contents
// s_axis   in   func in tuser, vertex fields in tdata
// m_axis   out  normals, tangents in tdata, flags in tuser
// One item at a time. A load or an unused code goes through S_OUT to the
// output register. A triangle reads its three corners, forms the cross
// product and tangent numerators, then the determinant, runs three tangent
// divides, writes back the three corners and outputs; a zero determinant
// skips the divides. A read normalizes the sum by shifts, then runs one root
// and three divides on the shared divide/root unit; a zero normal sum goes
// straight to output. Reset clears control only; vertex memory contents
// need a load before use. A stalled result holds in the output register
// and the next item waits for it to leave.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertex_normal_tangent_accumulate_macros.svh"
module vertex_normal_tangent_accumulate
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, corner_b, corner_c, pad
    input  logic [143:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z
    output logic [119:0] m_axis_tdata,
    // normal_zero, uv_degenerate
    output logic [1:0]   m_axis_tuser
);
    import vnt_pkg::*;

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam logic [63:0] SUM_MAX = 64'sd140737488355327;
    localparam logic [63:0] SUM_MIN = -64'sd140737488355328;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_RD    = 15'b000000000000010,
        S_CAP   = 15'b000000000000100,
        S_CROSS = 15'b000000000001000,
        S_CROSS2= 15'b000000000010000,
        S_TDIV  = 15'b000000000100000,
        S_TWAIT = 15'b000000001000000,
        S_WB    = 15'b000000010000000,
        S_NORM  = 15'b000000100000000,
        S_SQ    = 15'b000001000000000,
        S_SQW   = 15'b000010000000000,
        S_NDIV  = 15'b000100000000000,
        S_NWAIT = 15'b001000000000000,
        S_OUT   = 15'b010000000000000,
        S_SQ2   = 15'b100000000000000
    } state_t;

    // vertex memories: geometry and accumulators
    logic [107:0] geo_mem [VERTEX_COUNT];
    logic [215:0] acc_mem [VERTEX_COUNT];
    logic [107:0] geo_rd;
    logic [215:0] acc_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          geo_we, acc_we;
    logic [107:0]  geo_wd;
    logic [215:0]  acc_wd;

    always_ff @(posedge clk)
    begin
        if (geo_we)
            geo_mem[wr_addr] <= geo_wd;
        if (acc_we)
            acc_mem[wr_addr] <= acc_wd;
        geo_rd <= geo_mem[rd_addr];
        acc_rd <= acc_mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [1:0]  func_reg, func_next;
    logic [1:0]  k_reg, k_next;
    logic [AW-1:0] idx_reg [3];
    logic [AW-1:0] idx_next [3];
    logic [107:0] g_reg [3];
    logic [107:0] g_next [3];
    logic signed [63:0] n_reg [3];
    logic signed [63:0] n_next [3];
    logic signed [63:0] num_reg [3];
    logic signed [63:0] num_next [3];
    logic signed [23:0] t_reg [3];
    logic signed [23:0] t_next [3];
    logic signed [63:0] det_reg, det_next;
    logic [63:0]  m_reg [3];
    logic [63:0]  m_next [3];
    logic [63:0]  len_reg, len_next;
    logic         sgn_reg [3];
    logic         sgn_next [3];
    logic         ovld_reg, ovld_next;
    logic [119:0] od_reg, od_next;
    logic [1:0]   ou_reg, ou_next;
    vnt_div_req_t dreq;
    vnt_div_rsp_t drsp;
    logic         rd_pending_reg, rd_pending_next;

    vnt_divsqrt u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // helpers
    logic signed [24:0] e1 [3];
    logic signed [24:0] e2 [3];
    logic signed [18:0] d1u, d1v, d2u, d2v;
    logic signed [63:0] prod_a, prod_b, cr;
    logic signed [63:0] acc_old, acc_sum;
    logic [63:0] big, mk;
    logic [63:0] qabs;
    logic        neg;
    logic [63:0] sqsum;
    logic [AW-1:0] tmp_idx;

    function automatic logic signed [24:0] px(input logic [107:0] g, input int c);
        px = 25'(signed'(g[c*24 +: 24]));
    endfunction

    // edges and texture deltas of the captured corners
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = px(g_reg[1], i) - px(g_reg[0], i);
            e2[i] = px(g_reg[2], i) - px(g_reg[0], i);
        end
        d1u = 19'(signed'(g_reg[1][89:72])) - 19'(signed'(g_reg[0][89:72]));
        d1v = 19'(signed'(g_reg[0][107:90])) - 19'(signed'(g_reg[1][107:90]));
        d2u = 19'(signed'(g_reg[2][89:72])) - 19'(signed'(g_reg[0][89:72]));
        d2v = 19'(signed'(g_reg[0][107:90])) - 19'(signed'(g_reg[2][107:90]));
    end

    assign tmp_idx = idx_reg[k_reg];

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        k_next     = k_reg;
        det_next   = det_reg;
        len_next   = len_reg;
        ovld_next  = ovld_reg;
        od_next    = od_reg;
        ou_next    = ou_reg;
        rd_pending_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            idx_next[i] = idx_reg[i];
            g_next[i]   = g_reg[i];
            n_next[i]   = n_reg[i];
            num_next[i] = num_reg[i];
            t_next[i]   = t_reg[i];
            m_next[i]   = m_reg[i];
            sgn_next[i] = sgn_reg[i];
        end
        rd_addr = tmp_idx;
        wr_addr = tmp_idx;
        geo_we  = 1'b0;
        acc_we  = 1'b0;
        geo_wd  = s_axis_tdata[117:10];
        acc_wd  = '0;
        dreq    = '0;
        prod_a  = '0;
        prod_b  = '0;
        cr      = '0;
        acc_old = '0;
        acc_sum = '0;
        big     = '0;
        mk      = '0;
        qabs    = drsp.quo;
        neg     = 1'b0;
        sqsum   = '0;
        s_axis_tready = (state_reg == S_IDLE) && !ovld_reg;

        if (ovld_reg && m_axis_tready)
            ovld_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    func_next   = s_axis_tuser;
                    idx_next[0] = AW'(s_axis_tdata[9:0] % VERTEX_COUNT);
                    idx_next[1] = AW'(s_axis_tdata[127:118] % VERTEX_COUNT);
                    idx_next[2] = AW'(s_axis_tdata[137:128] % VERTEX_COUNT);
                    k_next      = 2'd0;
                    od_next     = '0;
                    ou_next     = '0;
                    if (s_axis_tuser == FUNC_LOAD)
                    begin
                        wr_addr = AW'(s_axis_tdata[9:0] % VERTEX_COUNT);
                        geo_we  = 1'b1;
                        geo_wd  = s_axis_tdata[117:10];
                        acc_we  = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (s_axis_tuser == FUNC_TRI || s_axis_tuser == FUNC_READ)
                        state_next = S_RD;
                    else
                        state_next = S_OUT;
                end
            end
            S_RD:
            begin
                rd_pending_next = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                g_next[k_reg] = geo_rd;
                if (func_reg == FUNC_READ)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        n_next[i]   = 64'(signed'(acc_rd[i*48 +: 48]));
                        sgn_next[i] = acc_rd[i*48 + 47];
                        m_next[i]   = acc_rd[i*48 + 47] ?
                            64'd0 - 64'(signed'(acc_rd[i*48 +: 48])) :
                            64'(acc_rd[i*48 +: 48]);
                    end
                    od_next[119:48] = acc_rd[215:144];
                    state_next = S_NORM;
                end
                else if (k_reg == 2'd2)
                begin
                    k_next = 2'd0;
                    state_next = S_CROSS;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_CROSS:
            begin
                // one cross component, one tangent numerator per cycle
                unique case (k_reg)
                    2'd0:
                    begin
                        prod_a = 64'(e1[1]) * 64'(e2[2]);
                        prod_b = 64'(e1[2]) * 64'(e2[1]);
                    end
                    2'd1:
                    begin
                        prod_a = 64'(e1[2]) * 64'(e2[0]);
                        prod_b = 64'(e1[0]) * 64'(e2[2]);
                    end
                    default:
                    begin
                        prod_a = 64'(e1[0]) * 64'(e2[1]);
                        prod_b = 64'(e1[1]) * 64'(e2[0]);
                    end
                endcase
                cr = prod_a - prod_b;
                n_next[k_reg] = cr >>> 16;
                num_next[k_reg] = 64'(d2v) * 64'(e1[k_reg]) - 64'(d1v) * 64'(e2[k_reg]);
                if (k_reg == 2'd2)
                begin
                    k_next = 2'd0;
                    state_next = S_CROSS2;
                end
                else
                    k_next = k_reg + 2'd1;
            end
            S_CROSS2:
            begin
                det_next = 64'(d1u) * 64'(d2v) - 64'(d1v) * 64'(d2u);
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                if (det_reg == 0)
                begin
                    for (int i = 0; i < 3; i++)
                        t_next[i] = '0;
                    ou_next[1] = 1'b1;
                    k_next = 2'd0;
                    state_next = S_WB;
                    rd_addr = idx_reg[0];
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num = (num_reg[k_reg][63] ? 64'(-num_reg[k_reg]) :
                        64'(num_reg[k_reg])) << 16;
                    dreq.den = det_reg[63] ? 64'(-det_reg) : 64'(det_reg);
                    state_next = S_TWAIT;
                end
            end
            S_TWAIT:
            begin
                if (drsp.done)
                begin
                    neg = num_reg[k_reg][63] ^ det_reg[63];
                    if (neg)
                        t_next[k_reg] = (qabs > 64'd8388608) ? 24'sh800000 :
                            24'(-qabs);
                    else
                        t_next[k_reg] = (qabs > 64'd8388607) ? 24'sh7FFFFF :
                            24'(qabs);
                    if (k_reg == 2'd2)
                    begin
                        k_next = 2'd0;
                        rd_addr = idx_reg[0];
                        state_next = S_WB;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                        state_next = S_TDIV;
                    end
                end
            end
            S_WB:
            begin
                // issue the read of this corner, or, if it was issued last cycle, add and write back
                if (!rd_pending_reg)
                begin
                    rd_addr = idx_reg[k_reg];
                    rd_pending_next = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        acc_old = 64'(signed'(acc_rd[i*48 +: 48]));
                        acc_sum = acc_old + n_reg[i];
                        if (acc_sum > signed'(SUM_MAX))
                            acc_sum = SUM_MAX;
                        else if (acc_sum < signed'(SUM_MIN))
                            acc_sum = SUM_MIN;
                        acc_wd[i*48 +: 48] = acc_sum[47:0];
                    end
                    acc_wd[215:144] = {t_reg[2], t_reg[1], t_reg[0]};
                    wr_addr = idx_reg[k_reg];
                    acc_we  = 1'b1;
                    if (k_reg == 2'd2)
                    begin
                        od_next[119:48] = {t_reg[2], t_reg[1], t_reg[0]};
                        state_next = S_OUT;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            S_NORM:
            begin
                big = (m_reg[0] > m_reg[1]) ? m_reg[0] : m_reg[1];
                big = (big > m_reg[2]) ? big : m_reg[2];
                if (big == 0)
                begin
                    ou_next[0] = 1'b1;
                    state_next = S_OUT;
                end
                else if (big >= 64'h4000_0000)
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] >> 1;
                end
                else if (big < 64'h2000_0000)
                begin
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] << 1;
                end
                else
                begin
                    k_next = 2'd0;
                    len_next = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                // accumulate one square per cycle
                len_next = len_reg + m_reg[k_reg][31:0] * m_reg[k_reg][31:0];
                if (k_reg == 2'd2)
                    state_next = S_SQ2;
                else
                    k_next = k_reg + 2'd1;
            end
            S_SQ2:
            begin
                sqsum = len_reg;
                dreq.start = 1'b1;
                dreq.is_sqrt = 1'b1;
                dreq.num = sqsum;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                if (drsp.done)
                begin
                    len_next = drsp.quo;
                    k_next = 2'd0;
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                dreq.start = 1'b1;
                dreq.num = m_reg[k_reg] << 14;
                dreq.den = len_reg;
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (drsp.done)
                begin
                    mk = sgn_reg[k_reg] ? 64'(-qabs) : qabs;
                    od_next[k_reg*16 +: 16] = mk[15:0];
                    if (k_reg == 2'd2)
                        state_next = S_OUT;
                    else
                    begin
                        k_next = k_reg + 2'd1;
                        state_next = S_NDIV;
                    end
                end
            end
            S_OUT:
            begin
                if (!ovld_reg)
                begin
                    ovld_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovld_reg  <= 1'b0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
            rd_pending_reg <= rd_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        k_reg    <= k_next;
        det_reg  <= det_next;
        len_reg  <= len_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
        for (int i = 0; i < 3; i++)
        begin
            idx_reg[i] <= idx_next[i];
            g_reg[i]   <= g_next[i];
            n_reg[i]   <= n_next[i];
            num_reg[i] <= num_next[i];
            t_reg[i]   <= t_next[i];
            m_reg[i]   <= m_next[i];
            sgn_reg[i] <= sgn_next[i];
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;

    `VNT_ASSERT(a_no_accept_busy, clk, rst_n, (state_reg != S_IDLE) |-> !s_axis_tready)
    `VNT_ASSERT(a_out_hold, clk, rst_n, ovld_reg && !m_axis_tready |=> $stable(od_reg))
    `VNT_ASSERT(a_flags_excl, clk, rst_n, ovld_reg |-> !(ou_reg[0] && ou_reg[1]))
endmodule

// ===== hw/rtl/vnt_divsqrt.sv =====
// ---------------------------------------------------------------------------
// vnt_divsqrt
// Shared radix-2 unsigned divider and bitwise integer square root.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertex_normal_tangent_accumulate_macros.svh"
module vnt_divsqrt
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vnt_pkg::vnt_div_req_t req,
    output vnt_pkg::vnt_div_rsp_t rsp
);
    import vnt_pkg::*;

    logic        busy_reg, busy_next;
    logic        sq_reg, sq_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] n_reg, n_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] b_reg, b_next;
    logic        done_reg, done_next;
    logic [64:0] rem_sh;
    logic [64:0] rb;

    // one quotient bit or one root step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        b_next    = b_reg;
        done_next = 1'b0;
        rem_sh    = {r_reg, n_reg[63]};
        rb        = {1'b0, r_reg} + {1'b0, b_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            sq_next   = req.is_sqrt;
            n_next    = req.num;
            d_next    = req.den;
            r_next    = '0;
            q_next    = '0;
            b_next    = 64'h4000_0000_0000_0000;
            cnt_next  = req.is_sqrt ? 7'd32 : 7'd64;
        end
        else if (busy_reg)
        begin
            if (sq_reg)
            begin
                if ({1'b0, n_reg} >= rb)
                begin
                    n_next = n_reg - rb[63:0];
                    r_next = (r_reg >> 1) + b_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                b_next = b_reg >> 2;
                q_next = r_next;
            end
            else
            begin
                n_next = {n_reg[62:0], 1'b0};
                if (rem_sh >= {1'b0, d_reg})
                begin
                    r_next = rem_sh[63:0] - d_reg;
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_next = rem_sh[63:0];
                    q_next = {q_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
        n_reg  <= n_next;
        d_reg  <= d_next;
        r_reg  <= r_next;
        q_reg  <= q_next;
        b_reg  <= b_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

    `VNT_ASSERT(a_done_after_busy, clk, rst_n, done_reg |-> $past(busy_reg))
    `VNT_ASSERT(a_no_restart, clk, rst_n, busy_reg |-> !req.start)
    `VNT_ASSERT(a_cnt_live, clk, rst_n, busy_reg |-> cnt_reg != 7'd0)
endmodule
